// File: hdl/pwl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and codes for the piecewise linear xyz lookup.
// ----------------------------------------------------------------------------
package pwl_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_BAD    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_EXACT  = 3'd1,
        ST_INTERP = 3'd2,
        ST_BEFORE = 3'd3,
        ST_AFTER  = 3'd4,
        ST_EMPTY  = 3'd5,
        ST_REJECT = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APPEND,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PREV_RD,
        S_PREV_LD,
        S_DIV,
        S_LAST_RD,
        S_LAST_LD,
        S_OUT
    } state_t;

    localparam int TIME_W = 32;
    localparam int IN_W   = 32;

    // controller -> datapath commands
    typedef struct packed {
        logic       load_req;
        logic       do_append;
        logic       do_clear;
        logic       scan_start;
        logic       scan_rd;
        logic       scan_adv;
        logic       rd_prev;
        logic       rd_last;
        logic       load_cur;
        logic       load_res;
        logic       div_start;
        logic       zero_res;
        logic       set_status;
        status_t    status;
    } pwl_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        kind_t      kind;
        logic       empty;
        logic       append_ok;
        logic       scan_end;
        logic       hit_exact;
        logic       hit_above;
        logic       first_entry;
        logic       div_done;
    } pwl_sts_t;

endpackage
`default_nettype wire

// File: hdl/pwl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_ctrl
// Sequencer: decodes a request, steps the table scan, starts division.
// ----------------------------------------------------------------------------
module pwl_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  res_valid,
    input  wire logic             res_ready,
    input  wire pwl_pkg::pwl_sts_t sts,
    output pwl_pkg::pwl_cmd_t     cmd
);

    pwl_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pwl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pwl_pkg::S_IDLE: begin
                if (req_valid) state_next = pwl_pkg::S_DECODE;
            end
            pwl_pkg::S_DECODE: begin
                unique case (sts.kind)
                    pwl_pkg::KIND_APPEND: state_next = pwl_pkg::S_APPEND;
                    pwl_pkg::KIND_QUERY:
                        state_next = sts.empty ? pwl_pkg::S_OUT : pwl_pkg::S_SCAN_RD;
                    default: state_next = pwl_pkg::S_OUT;
                endcase
            end
            pwl_pkg::S_APPEND:  state_next = pwl_pkg::S_OUT;
            pwl_pkg::S_SCAN_RD: state_next = pwl_pkg::S_SCAN_CHK;
            pwl_pkg::S_SCAN_CHK: begin
                priority if (sts.hit_exact) state_next = pwl_pkg::S_OUT;
                else if (sts.hit_above)
                    state_next = sts.first_entry ? pwl_pkg::S_OUT : pwl_pkg::S_PREV_RD;
                else if (sts.scan_end) state_next = pwl_pkg::S_LAST_RD;
                else state_next = pwl_pkg::S_SCAN_RD;
            end
            pwl_pkg::S_PREV_RD: state_next = pwl_pkg::S_PREV_LD;
            pwl_pkg::S_PREV_LD: state_next = pwl_pkg::S_DIV;
            pwl_pkg::S_DIV: begin
                if (sts.div_done) state_next = pwl_pkg::S_OUT;
            end
            pwl_pkg::S_LAST_RD: state_next = pwl_pkg::S_LAST_LD;
            pwl_pkg::S_LAST_LD: state_next = pwl_pkg::S_OUT;
            pwl_pkg::S_OUT: begin
                if (res_ready) state_next = pwl_pkg::S_IDLE;
            end
            default: state_next = pwl_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        cmd.status = pwl_pkg::ST_DONE;
        req_ready = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            pwl_pkg::S_IDLE: begin
                req_ready = 1'b1;
                cmd.load_req = req_valid;
            end
            pwl_pkg::S_DECODE: begin
                cmd.zero_res = 1'b1;
                cmd.set_status = 1'b1;
                cmd.scan_start = 1'b1;
                unique case (sts.kind)
                    pwl_pkg::KIND_APPEND: cmd.status = pwl_pkg::ST_DONE;
                    pwl_pkg::KIND_QUERY:
                        cmd.status = sts.empty ? pwl_pkg::ST_EMPTY : pwl_pkg::ST_AFTER;
                    pwl_pkg::KIND_CLEAR: begin
                        cmd.status = pwl_pkg::ST_DONE;
                        cmd.do_clear = 1'b1;
                    end
                    default: cmd.status = pwl_pkg::ST_REJECT;
                endcase
            end
            pwl_pkg::S_APPEND: begin
                cmd.set_status = 1'b1;
                cmd.status = sts.append_ok ? pwl_pkg::ST_DONE : pwl_pkg::ST_REJECT;
                cmd.do_append = sts.append_ok;
            end
            pwl_pkg::S_SCAN_RD: cmd.scan_rd = 1'b1;
            pwl_pkg::S_SCAN_CHK: begin
                cmd.load_cur = 1'b1;
                priority if (sts.hit_exact) begin
                    cmd.load_res = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status = pwl_pkg::ST_EXACT;
                end else if (sts.hit_above) begin
                    cmd.set_status = 1'b1;
                    cmd.status = sts.first_entry ? pwl_pkg::ST_BEFORE : pwl_pkg::ST_INTERP;
                end else begin
                    cmd.scan_adv = 1'b1;
                end
            end
            pwl_pkg::S_PREV_RD: cmd.rd_prev = 1'b1;
            pwl_pkg::S_PREV_LD: cmd.div_start = 1'b1;
            pwl_pkg::S_LAST_RD: cmd.rd_last = 1'b1;
            pwl_pkg::S_LAST_LD: cmd.load_res = 1'b1;
            pwl_pkg::S_OUT: res_valid = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/pwl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_div
// Restoring divider, one quotient bit per cycle: q = num / den.
// ----------------------------------------------------------------------------
module pwl_div #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   shifted;

    assign shifted = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    // shift one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (cnt_reg != '0) begin
            if (!trial[DEN_W]) begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule
`default_nettype wire

// File: hdl/pwl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_datapath
// Breakpoint memory, scan pointer, compare and per-axis interpolation.
// ----------------------------------------------------------------------------
module pwl_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [1:0]                  req_kind,
    input  wire logic [pwl_pkg::TIME_W-1:0]  req_time,
    input  wire logic [pwl_pkg::IN_W-1:0]    req_x,
    input  wire logic [pwl_pkg::IN_W-1:0]    req_y,
    input  wire logic [pwl_pkg::IN_W-1:0]    req_z,
    input  wire logic [15:0]                 tolerance,
    input  wire pwl_pkg::pwl_cmd_t           cmd,
    output pwl_pkg::pwl_sts_t                sts,
    output logic [pwl_pkg::IN_W-1:0]         res_x,
    output logic [pwl_pkg::IN_W-1:0]         res_y,
    output logic [pwl_pkg::IN_W-1:0]         res_z,
    output logic [2:0]                       res_status
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int VW  = VALUE_WIDTH;
    localparam int DVW = VW + 1;
    localparam int NW  = DVW + pwl_pkg::TIME_W;
    localparam int MW  = 3 * VW;
    localparam logic signed [VW:0] VMAX = (VW+1)'((65'sd1 <<< (VW - 1)) - 1);
    localparam logic signed [VW:0] VMIN = -VMAX - 1;

    // memory row: time and three values
    logic [pwl_pkg::TIME_W+MW-1:0] mem [TABLE_DEPTH];
    logic [pwl_pkg::TIME_W+MW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic [1:0]                 kind_reg;
    logic [pwl_pkg::TIME_W-1:0] t_reg;
    logic [pwl_pkg::IN_W-1:0]   x_reg, y_reg, z_reg;
    logic [CW-1:0]              count_reg;
    logic [pwl_pkg::TIME_W-1:0] last_t_reg;
    logic [CW-1:0]              idx_reg;

    logic [pwl_pkg::TIME_W-1:0] cur_t_reg;
    logic [MW-1:0]              cur_v_reg;
    logic [VW-1:0]              x_res_reg, y_res_reg, z_res_reg;
    logic [2:0]                 status_reg;

    // saturate an input word to the value range
    function automatic logic [VW-1:0] sat_in(input logic [pwl_pkg::IN_W-1:0] v);
        logic signed [64:0] w;
        w = 65'(signed'(v));
        if (w > 65'(VMAX)) return VMAX[VW-1:0];
        if (w < 65'(VMIN)) return VMIN[VW-1:0];
        return w[VW-1:0];
    endfunction

    // latch request
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            kind_reg <= req_kind;
            t_reg    <= req_time;
            x_reg    <= req_x;
            y_reg    <= req_y;
            z_reg    <= req_z;
        end
    end

    // table fill count and last time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.do_clear) begin
            count_reg <= '0;
        end else if (cmd.do_append) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_append) last_t_reg <= t_reg;
    end

    // memory write and registered read
    always_comb begin
        priority if (cmd.rd_prev) rd_addr = AW'(idx_reg - 1'b1);
        else if (cmd.rd_last) rd_addr = AW'(count_reg - 1'b1);
        else rd_addr = idx_reg[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_append)
            mem[count_reg[AW-1:0]] <= {sat_in(z_reg), sat_in(y_reg), sat_in(x_reg), t_reg};
        rd_data_reg <= mem[rd_addr];
    end

    // scan pointer
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) idx_reg <= '0;
        else if (cmd.scan_adv) idx_reg <= idx_reg + 1'b1;
    end

    // compare current entry with query
    logic [pwl_pkg::TIME_W-1:0] ti, diff;
    assign ti   = rd_data_reg[pwl_pkg::TIME_W-1:0];
    assign diff = (ti >= t_reg) ? ti - t_reg : t_reg - ti;

    always_ff @(posedge aclk) begin
        if (cmd.load_cur) begin
            cur_t_reg <= ti;
            cur_v_reg <= rd_data_reg[pwl_pkg::TIME_W+:MW];
        end
    end

    // division setup: one axis per pass
    logic [1:0]                 axis_reg;
    logic                       div_run_reg;
    logic [pwl_pkg::TIME_W-1:0] t0_reg;
    logic [MW-1:0]              v0s_reg;
    logic                       div_start, div_busy, div_busy_d;
    logic [NW-1:0]              div_num, div_quot;
    logic signed [DVW-1:0]      v0a, v1a, dv;
    logic [DVW-1:0]             mag;
    logic [pwl_pkg::TIME_W-1:0] off, dt;
    logic [NW-1:0]              prod_reg;
    logic                       neg_reg;
    logic                       prod_ok_reg;
    logic                       prod_ok_d_reg;
    logic signed [NW:0]         sum;
    logic [VW-1:0]              sat_out;

    always_comb begin
        v0a = DVW'(signed'(v0s_reg[axis_reg*VW+:VW]));
        v1a = DVW'(signed'(cur_v_reg[axis_reg*VW+:VW]));
        dv  = v1a - v0a;
        mag = dv[DVW-1] ? DVW'(-dv) : DVW'(dv);
        off = t_reg - t0_reg;
        dt  = cur_t_reg - t0_reg;
    end

    // stage the product, then start the divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_run_reg   <= 1'b0;
            prod_ok_reg   <= 1'b0;
            prod_ok_d_reg <= 1'b0;
            axis_reg      <= '0;
        end else begin
            prod_ok_reg   <= 1'b0;
            // delay the start until the product of the settled operands is registered
            prod_ok_d_reg <= prod_ok_reg;
            if (cmd.div_start) begin
                div_run_reg <= 1'b1;
                axis_reg    <= '0;
                prod_ok_reg <= 1'b1;
            end else if (div_run_reg && div_busy_d && !div_busy) begin
                if (axis_reg == 2'd2) begin
                    div_run_reg <= 1'b0;
                end else begin
                    axis_reg    <= axis_reg + 1'b1;
                    prod_ok_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            t0_reg  <= rd_data_reg[pwl_pkg::TIME_W-1:0];
            v0s_reg <= rd_data_reg[pwl_pkg::TIME_W+:MW];
        end
        div_busy_d <= div_busy;
        prod_reg   <= NW'(mag) * NW'(off);
        neg_reg    <= dv[DVW-1];
    end

    assign div_start = prod_ok_d_reg;
    assign div_num   = prod_reg;

    pwl_div #(.NUM_W(NW), .DEN_W(pwl_pkg::TIME_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dt),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    always_comb begin
        sum = neg_reg ? (NW+1)'(signed'(v0a)) - signed'({1'b0, div_quot})
                      : (NW+1)'(signed'(v0a)) + signed'({1'b0, div_quot});
        if (sum > (NW+1)'(VMAX)) sat_out = VMAX[VW-1:0];
        else if (sum < (NW+1)'(VMIN)) sat_out = VMIN[VW-1:0];
        else sat_out = sum[VW-1:0];
    end

    logic div_fin;
    assign div_fin = div_run_reg && div_busy_d && !div_busy;

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.zero_res) begin
            x_res_reg <= '0;
            y_res_reg <= '0;
            z_res_reg <= '0;
        end else if (cmd.load_res) begin
            x_res_reg <= rd_data_reg[pwl_pkg::TIME_W+:VW];
            y_res_reg <= rd_data_reg[pwl_pkg::TIME_W+VW+:VW];
            z_res_reg <= rd_data_reg[pwl_pkg::TIME_W+2*VW+:VW];
        end else if (div_fin) begin
            unique case (axis_reg)
                2'd0:    x_res_reg <= sat_out;
                2'd1:    y_res_reg <= sat_out;
                default: z_res_reg <= sat_out;
            endcase
        end
        if (cmd.set_status) status_reg <= cmd.status;
    end

    // status to controller
    always_comb begin
        sts.kind        = pwl_pkg::kind_t'(kind_reg);
        sts.empty       = (count_reg == '0);
        sts.append_ok   = (count_reg != CW'(TABLE_DEPTH)) &&
                          ((count_reg == '0) || (t_reg > last_t_reg));
        sts.scan_end    = (idx_reg + 1'b1 == count_reg);
        sts.hit_exact   = (diff < pwl_pkg::TIME_W'(tolerance));
        sts.hit_above   = !(ti < t_reg);
        sts.first_entry = (idx_reg == '0);
        sts.div_done    = div_fin && (axis_reg == 2'd2);
    end

    assign res_x      = pwl_pkg::IN_W'(signed'(x_res_reg));
    assign res_y      = pwl_pkg::IN_W'(signed'(y_res_reg));
    assign res_z      = pwl_pkg::IN_W'(signed'(z_res_reg));
    assign res_status = status_reg;

endmodule
`default_nettype wire

// File: hdl/piecewise_linear_xyz_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_xyz_lookup
// Breakpoint table of (time, x, y, z) with append, clear and interpolated query.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata (low bit up)                    | tuser
// s_      | in  | sample_time, in_x, in_y, in_z (128)   | kind (2)
// m_      | out | out_x, out_y, out_z (96)              | status (3)
//
// One request at a time. Append, clear, reject and empty query go straight to the
// result. A query scans entries in order until one matches or lies above; past
// the last entry it returns that entry, and between two entries it runs the
// bit-serial divider once per axis to interpolate.
// aresetn is synchronous active low and empties the table; memory is not cleared.
// A stalled result holds m_ outputs until taken; s_tready is low meanwhile.
// ----------------------------------------------------------------------------
module piecewise_linear_xyz_lookup #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,      // match_tolerance
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,          // sample_time, in_x, in_y, in_z
    input  wire logic [1:0]   s_tuser,          // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,          // out_x, out_y, out_z
    output logic [2:0]        m_tuser           // status
);

    logic [15:0] tol_reg;
    pwl_pkg::pwl_cmd_t cmd;
    pwl_pkg::pwl_sts_t sts;
    logic [31:0] rx, ry, rz;

    // hold tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= 16'd1;
        else if (cfg_wr_en) tol_reg <= cfg_wr_data;
    end

    pwl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pwl_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_kind   (s_tuser),
        .req_time   (s_tdata[31:0]),
        .req_x      (s_tdata[63:32]),
        .req_y      (s_tdata[95:64]),
        .req_z      (s_tdata[127:96]),
        .tolerance  (tol_reg),
        .cmd        (cmd),
        .sts        (sts),
        .res_x      (rx),
        .res_y      (ry),
        .res_z      (rz),
        .res_status (m_tuser)
    );

    assign m_tdata = {rz, ry, rx};

    // never accept while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("accept during pending result");

    // a taken result returns the block to idle, ready for a request
    a_res_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> s_tready) else $error("no return to idle");

    // commands to append and clear never coincide
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.do_append && cmd.do_clear)) else $error("append and clear together");

endmodule
`default_nettype wire
